// ===== sv/swbd_pkg.sv =====
// Shared constants and types for the spectral watermark bit detector.
// No dependencies; every other file of the block imports this package.
package swbd_pkg;

   // Default geometry of the detector
   localparam int GROUP_SIZE_DEF = 10;
   localparam int BIN_WIDTH_DEF  = 24;

   // Q0.16 unity for the threshold factor
   localparam int Q16_ONE = 65536;

   // Control/status register map
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_FACTOR = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESSAGE_LENGTH   = 4'd1;

   // Register field widths and reset values
   localparam int FACTOR_W = 16;
   localparam int CHAR_W   = 8;
   localparam logic [FACTOR_W-1:0] THRESHOLD_FACTOR_RST = 16'd6554;
   localparam logic [CHAR_W-1:0]   MESSAGE_LENGTH_RST   = 8'd21;

   typedef logic [FACTOR_W-1:0]   factor_type;
   typedef logic [CHAR_W-1:0]     char_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

// ===== sv/swbd_ifs.sv =====
// Handshake channels of the detector: bin input, bit result, register write.
// Depends on swbd_pkg for widths and types.

interface swbd_bin_if
   import swbd_pkg::*;
   #(parameter int BIN_WIDTH = BIN_WIDTH_DEF) ();
   logic                        valid;
   logic                        ready;
   logic signed [BIN_WIDTH-1:0] real_part;
   logic signed [BIN_WIDTH-1:0] imag_part;
   modport source (output valid, real_part, imag_part, input ready);
   modport sink   (input valid, real_part, imag_part, output ready);
endinterface

interface swbd_rsp_if
   import swbd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     decoded_bit;
   char_type char_value;
   logic     char_done;
   logic     message_done;
   modport source (output valid, decoded_bit, char_value, char_done, message_done,
                   input ready);
   modport sink   (input valid, decoded_bit, char_value, char_done, message_done,
                   output ready);
endinterface

interface swbd_csr_if
   import swbd_pkg::*;
   ();
   logic         valid;
   logic         ready;
   csr_idx_type  wr_index;
   csr_data_type wr_data;
   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ===== sv/spectral_watermark_bit_detector_core.sv =====
// Spectral watermark bit detector: one complex bin per input word, one bit word per group.
// Imports swbd_pkg; uses swbd_ifs, swbd_mult and swbd_isqrt.
//
// Each bin passes through these steps: the accepting state, the shared multiplier for the
// squares of the real and the imaginary part, a step to add them, then the bit-serial
// square root, which gives one root bit per cycle, and the store of the magnitude.
// The input is not ready while a bin or a group decision is in progress. The
// last bin of a group is followed by the group decision: two threshold products on the
// same multiplier, then the first GROUP_SIZE-1 stored magnitudes read one by one from the
// group memory to vote. A finished bit word waits in the output register; the next bin is
// accepted meanwhile, and only the following group decision waits for it to be taken.
// The register write port is always ready and takes effect on the next cycle.
module spectral_watermark_bit_detector_core
   import swbd_pkg::*;
   #(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF,
   parameter int BIN_WIDTH  = BIN_WIDTH_DEF
   ) (
   input  logic       clock,
   input  logic       reset,
   swbd_bin_if.sink   req_chan,
   swbd_rsp_if.source rsp_chan,
   swbd_csr_if.sink   csr_chan
);

   localparam int MAG_W  = BIN_WIDTH + 1;
   localparam int POS_W  = $clog2(GROUP_SIZE);
   localparam int SUM_W  = MAG_W + $clog2(GROUP_SIZE);
   localparam int OPB_W  = (BIN_WIDTH > 18) ? BIN_WIDTH : 18;
   localparam int PROD_W = SUM_W + OPB_W;
   localparam int RAD_W  = 2 * BIN_WIDTH;
   localparam int CMP_W  = SUM_W + 18;

   // sequencer codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SQ_RE    = 4'd1;
   localparam logic [3:0] S_SQ_IM    = 4'd2;
   localparam logic [3:0] S_SQ_ADD   = 4'd3;
   localparam logic [3:0] S_ROOT     = 4'd4;
   localparam logic [3:0] S_REF_LO   = 4'd5;
   localparam logic [3:0] S_REF_HI   = 4'd6;
   localparam logic [3:0] S_REF_WAIT = 4'd7;
   localparam logic [3:0] S_FETCH    = 4'd8;
   localparam logic [3:0] S_CMP      = 4'd9;
   localparam logic [3:0] S_DECIDE   = 4'd10;

   logic [3:0]           state_ff, state_in;
   factor_type           factor_ff, factor_in;
   char_type             length_ff, length_in;
   logic [BIN_WIDTH-1:0] abs_re_ff, abs_re_in;
   logic [BIN_WIDTH-1:0] abs_im_ff, abs_im_in;
   logic [RAD_W-1:0]     radicand_ff, radicand_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     vote_idx_ff, vote_idx_in;
   logic [POS_W-1:0]     ones_ff, ones_in;
   logic [CMP_W-1:0]     lo_ref_ff, lo_ref_in;
   logic [CMP_W-1:0]     hi_ref_ff, hi_ref_in;
   char_type             shift_ff, shift_in;
   logic [2:0]           bitpos_ff, bitpos_in;
   char_type             count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   char_type             rsp_char_ff, rsp_char_in;
   logic                 rsp_cdone_ff, rsp_cdone_in;
   logic                 rsp_mdone_ff, rsp_mdone_in;

   logic [MAG_W-1:0]     store_mem [GROUP_SIZE];
   logic [MAG_W-1:0]     rd_data_ff;

   logic [SUM_W-1:0]     mul_a;
   logic [OPB_W-1:0]     mul_b;
   logic [PROD_W-1:0]    product;
   logic                 root_start;
   logic [RAD_W-1:0]     root_radicand;
   logic                 root_done;
   logic [BIN_WIDTH-1:0] root;
   logic [MAG_W-1:0]     mag;
   logic                 store_we;
   logic [CMP_W-1:0]     lhs;
   logic                 zero_vote;
   logic                 bit_val;
   logic                 rsp_free;
   char_type             shifted;
   logic [2:0]           bitpos_next;
   char_type             count_next;
   logic                 cdone;
   logic                 mdone;

   // shared multiplier and square root
   swbd_mult #(.A_W(SUM_W), .B_W(OPB_W)) u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   swbd_isqrt #(.ROOT_W(BIN_WIDTH)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_radicand),
      .done     (root_done),
      .root     (root)
   );

   assign mag           = MAG_W'(root);
   assign root_radicand = radicand_ff + product[RAD_W-1:0];
   assign root_start    = (state_ff == S_SQ_ADD);
   assign store_we      = (state_ff == S_ROOT) && root_done;

   // multiplier operand select
   always_comb begin
      case (state_ff)
         S_SQ_RE: begin
            mul_a = SUM_W'(abs_re_ff);
            mul_b = OPB_W'(abs_re_ff);
         end
         S_SQ_IM: begin
            mul_a = SUM_W'(abs_im_ff);
            mul_b = OPB_W'(abs_im_ff);
         end
         S_REF_LO: begin
            mul_a = sum_ff;
            mul_b = OPB_W'(Q16_ONE) + OPB_W'(factor_ff);
         end
         S_REF_HI: begin
            mul_a = sum_ff;
            mul_b = OPB_W'(3 * Q16_ONE) - OPB_W'(factor_ff);
         end
         default: begin
            mul_a = SUM_W'(abs_re_ff);
            mul_b = OPB_W'(abs_re_ff);
         end
      endcase
   end

   // group memory: written when a root is done, read at the vote index
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[pos_ff] <= mag;
      end
      rd_data_ff <= store_mem[vote_idx_ff];
   end

   // vote of one stored magnitude: 2*G*65536*m against the thresholds
   assign lhs       = (CMP_W'(rd_data_ff) * CMP_W'(2 * GROUP_SIZE)) << 16;
   assign zero_vote = (vote_idx_ff < POS_W'(GROUP_SIZE / 2)) ? (lhs >= lo_ref_ff)
                                                            : (lhs < hi_ref_ff);
   assign bit_val   = ({1'b0, ones_ff, 1'b0} > (POS_W+2)'(GROUP_SIZE - 1));

   // character assembly
   assign shifted     = {shift_ff[CHAR_W-2:0], bit_val};
   assign bitpos_next = bitpos_ff + 3'd1;
   assign cdone       = (bitpos_next == 3'd0);
   assign count_next  = count_ff + 8'd1;
   assign mdone       = cdone && (count_next == length_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      abs_re_in    = abs_re_ff;
      abs_im_in    = abs_im_ff;
      radicand_in  = radicand_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      vote_idx_in  = vote_idx_ff;
      ones_in      = ones_ff;
      lo_ref_in    = lo_ref_ff;
      hi_ref_in    = hi_ref_ff;
      shift_in     = shift_ff;
      bitpos_in    = bitpos_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_cdone_in = rsp_cdone_ff;
      rsp_mdone_in = rsp_mdone_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               abs_re_in = req_chan.real_part[BIN_WIDTH-1]
                         ? (~req_chan.real_part + 1'b1) : req_chan.real_part;
               abs_im_in = req_chan.imag_part[BIN_WIDTH-1]
                         ? (~req_chan.imag_part + 1'b1) : req_chan.imag_part;
               state_in  = S_SQ_RE;
            end
         end
         S_SQ_RE: begin
            state_in = S_SQ_IM;
         end
         S_SQ_IM: begin
            radicand_in = product[RAD_W-1:0];
            state_in    = S_SQ_ADD;
         end
         S_SQ_ADD: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_done) begin
               sum_in = sum_ff + SUM_W'(mag);
               if (pos_ff == POS_W'(GROUP_SIZE - 1)) begin
                  vote_idx_in = '0;
                  ones_in     = '0;
                  state_in    = S_REF_LO;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_REF_LO: begin
            state_in = S_REF_HI;
         end
         S_REF_HI: begin
            lo_ref_in = product[CMP_W-1:0];
            state_in  = S_REF_WAIT;
         end
         S_REF_WAIT: begin
            hi_ref_in = product[CMP_W-1:0];
            state_in  = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!zero_vote) begin
               ones_in = ones_ff + 1'b1;
            end
            if (vote_idx_ff == POS_W'(GROUP_SIZE - 2)) begin
               state_in = S_DECIDE;
            end else begin
               vote_idx_in = vote_idx_ff + 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = bit_val;
               rsp_char_in  = cdone ? shifted : '0;
               rsp_cdone_in = cdone;
               rsp_mdone_in = mdone;
               shift_in     = shifted;
               bitpos_in    = bitpos_next;
               if (cdone) begin
                  count_in = mdone ? '0 : count_next;
               end
               sum_in   = '0;
               pos_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      factor_in = factor_ff;
      length_in = length_ff;
      if (csr_chan.valid) begin
         case (csr_chan.wr_index)
            CSR_THRESHOLD_FACTOR: factor_in = csr_chan.wr_data;
            CSR_MESSAGE_LENGTH:   length_in = csr_chan.wr_data[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         factor_ff    <= THRESHOLD_FACTOR_RST;
         length_ff    <= MESSAGE_LENGTH_RST;
         sum_ff       <= '0;
         pos_ff       <= '0;
         vote_idx_ff  <= '0;
         ones_ff      <= '0;
         shift_ff     <= '0;
         bitpos_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         length_ff    <= length_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         vote_idx_ff  <= vote_idx_in;
         ones_ff      <= ones_in;
         shift_ff     <= shift_in;
         bitpos_ff    <= bitpos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      abs_re_ff    <= abs_re_in;
      abs_im_ff    <= abs_im_in;
      radicand_ff  <= radicand_in;
      lo_ref_ff    <= lo_ref_in;
      hi_ref_ff    <= hi_ref_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_cdone_ff <= rsp_cdone_in;
      rsp_mdone_ff <= rsp_mdone_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.decoded_bit  = rsp_bit_ff;
   assign rsp_chan.char_value   = rsp_char_ff;
   assign rsp_chan.char_done    = rsp_cdone_ff;
   assign rsp_chan.message_done = rsp_mdone_ff;

endmodule

// ===== sv/swbd_mult.sv =====
// Shared unsigned multiplier with a registered product.
// Used for the bin squares and the two group thresholds; imports swbd_pkg.
module swbd_mult
   import swbd_pkg::*;
   #(
   parameter int A_W = 29,
   parameter int B_W = 24
   ) (
   input  logic               clock,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic [A_W+B_W-1:0] product
);

   logic [A_W+B_W-1:0] product_ff;
   logic [A_W+B_W-1:0] product_in;

   // one multiply per cycle, result in the next cycle
   assign product_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== sv/swbd_isqrt.sv =====
// Bit-serial truncated square root: one root bit per cycle.
// Imports swbd_pkg; instantiated by the detector core.
module swbd_isqrt
   import swbd_pkg::*;
   #(
   parameter int ROOT_W = 24
   ) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // bring down the next two radicand bits and try root*4+1
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
